// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the RTL of the generation engine.
// Expects a clock named aclk and an active-low reset named aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define ASSERT_CLK(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(name, cond, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error(msg);

`endif

// ===== hw/rtl/lge_pkg.sv =====
// Package for the generation engine: grid size defaults, field widths and opcodes.
// No dependencies.
`default_nettype none

package lge_pkg;

    localparam int ROWS_DEF = 32;
    localparam int COLS_DEF = 32;

    localparam int OPCODE_W = 2;
    localparam int IDX_W    = 5;

    typedef enum logic [OPCODE_W-1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_STEP  = 2'd2,
        OP_CLEAR = 2'd3
    } opcode_t;

endpackage

`default_nettype wire

// ===== hw/rtl/life_generation_engine_core.sv =====
// Top level of the toroidal generation engine: grid memory, command sequencer, row stepper.
// Depends on lge_pkg and assert_macros.svh.
`default_nettype none

// The grid is held one row per memory word in a single memory of two banks; the
// active bank is the current generation and a step builds the next one in the
// other bank, then swaps banks. Every command returns exactly one result beat.
// A write or read goes from accept through row fetch, modify or pick, and the
// result register; a step with running clear goes straight to the result
// register. The memory has a single read port, which delivers one row per
// cycle. After reset the block runs a clearing pass over the active bank, with
// s_ready low; configuration writes are taken at any time. The next command is
// accepted while a finished result still waits on the m_ channel.
module life_generation_engine_core #(
    parameter int ROWS = lge_pkg::ROWS_DEF,
    parameter int COLS = lge_pkg::COLS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,

    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic                          cfg_data,

    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [lge_pkg::OPCODE_W-1:0]  s_opcode,
    input  wire logic [lge_pkg::IDX_W-1:0]     s_row_index,
    input  wire logic [lge_pkg::IDX_W-1:0]     s_col_index,
    input  wire logic                          s_cell_in,

    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_cell_out,
    output logic                               m_stepped
);

    import lge_pkg::*;

    `include "assert_macros.svh"

    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLS);
    localparam int RIW   = (RW > IDX_W) ? RW : IDX_W;
    localparam int CIW   = (CW > IDX_W) ? CW : IDX_W;
    localparam int CNTW  = $clog2(ROWS + 3);
    localparam int AW    = RW + 1;
    localparam int DEPTH = 2 * (1 << RW);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FETCH,
        ST_APPLY,
        ST_STEP,
        ST_FINISH
    } state_t;

    state_t            state_reg;
    logic [CNTW-1:0]   cnt_reg;
    logic              bank_reg;
    opcode_t           op_reg;
    logic [RW-1:0]     row_reg;
    logic [CW-1:0]     col_reg;
    logic              bit_reg;
    logic              inside_reg;
    logic              clr_resp_reg;
    logic              res_cell_reg;
    logic              res_step_reg;
    logic              m_valid_reg;
    logic              m_cell_reg;
    logic              m_step_reg;
    logic              running_reg;
    logic [COLS-1:0]   up_reg;
    logic [COLS-1:0]   mid_reg;
    logic [COLS-1:0]   rd_data_reg;

    logic [COLS-1:0]   grid_mem [DEPTH];

    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic [COLS-1:0]   wr_data;
    logic              wr_en;

    logic [RIW-1:0]    row_ext;
    logic [CIW-1:0]    col_ext;
    logic              in_inside;

    logic [CNTW-1:0]   step_k;
    logic [CNTW-1:0]   step_w;
    logic [RW-1:0]     step_rd_row;
    logic [RW-1:0]     step_wr_row;
    logic [COLS-1:0]   next_row;

    logic [COLS-1:0]   up_l;
    logic [COLS-1:0]   up_r;
    logic [COLS-1:0]   mid_l;
    logic [COLS-1:0]   mid_r;
    logic [COLS-1:0]   dn_l;
    logic [COLS-1:0]   dn_r;

    assign cfg_ready  = 1'b1;
    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_cell_out = m_cell_reg;
    assign m_stepped  = m_step_reg;

    assign row_ext   = RIW'(s_row_index);
    assign col_ext   = CIW'(s_col_index);
    assign in_inside = ({1'b0, row_ext} < (RIW + 1)'(ROWS))
                    && ({1'b0, col_ext} < (CIW + 1)'(COLS));

    // Read k of a step fetches row k-1, wrapping at both ends, so the window
    // enters with the last row above row 0 and leaves with row 0 below the last.
    assign step_k = cnt_reg - CNTW'(1);
    assign step_w = cnt_reg - CNTW'(3);
    assign step_wr_row = step_w[RW-1:0];

    always_comb begin
        if (cnt_reg == '0) begin
            step_rd_row = RW'(ROWS - 1);
        end else if (step_k == CNTW'(ROWS)) begin
            step_rd_row = '0;
        end else begin
            step_rd_row = step_k[RW-1:0];
        end
    end

    // Left and right neighbors of every column, wrapping at the row ends.
    assign up_l  = {up_reg[COLS-2:0], up_reg[COLS-1]};
    assign up_r  = {up_reg[0], up_reg[COLS-1:1]};
    assign mid_l = {mid_reg[COLS-2:0], mid_reg[COLS-1]};
    assign mid_r = {mid_reg[0], mid_reg[COLS-1:1]};
    assign dn_l  = {rd_data_reg[COLS-2:0], rd_data_reg[COLS-1]};
    assign dn_r  = {rd_data_reg[0], rd_data_reg[COLS-1:1]};

    // Next generation of the middle row of the window; rd_data_reg is the row below.
    for (genvar gc = 0; gc < COLS; gc++) begin : g_col
        logic [3:0] n;
        assign n = 4'(up_l[gc]) + 4'(up_reg[gc]) + 4'(up_r[gc])
                 + 4'(mid_l[gc]) + 4'(mid_r[gc])
                 + 4'(dn_l[gc]) + 4'(rd_data_reg[gc]) + 4'(dn_r[gc]);
        assign next_row[gc] = (n == 4'd3) || (mid_reg[gc] && (n == 4'd2));
    end

    always_comb begin
        rd_addr = {bank_reg, row_reg};
        wr_en   = 1'b0;
        wr_addr = {bank_reg, row_reg};
        wr_data = rd_data_reg;
        case (state_reg)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = {bank_reg, cnt_reg[RW-1:0]};
                wr_data = '0;
            end
            ST_APPLY: begin
                wr_en = (op_reg == OP_WRITE) && inside_reg;
                wr_data[col_reg] = bit_reg;
            end
            ST_STEP: begin
                rd_addr = {bank_reg, step_rd_row};
                wr_en   = (cnt_reg >= CNTW'(3));
                wr_addr = {~bank_reg, step_wr_row};
                wr_data = next_row;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            grid_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= grid_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            cnt_reg      <= '0;
            bank_reg     <= 1'b0;
            clr_resp_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            running_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                running_reg <= cfg_data;
            end
            // In ST_FINISH the result register is reloaded below instead.
            if (m_valid_reg && m_ready && (state_reg != ST_FINISH)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    if (cnt_reg == CNTW'(ROWS - 1)) begin
                        cnt_reg      <= '0;
                        res_cell_reg <= 1'b0;
                        res_step_reg <= 1'b0;
                        state_reg    <= clr_resp_reg ? ST_FINISH : ST_IDLE;
                    end else begin
                        cnt_reg <= cnt_reg + CNTW'(1);
                    end
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        op_reg       <= opcode_t'(s_opcode);
                        row_reg      <= row_ext[RW-1:0];
                        col_reg      <= col_ext[CW-1:0];
                        bit_reg      <= s_cell_in;
                        inside_reg   <= in_inside;
                        cnt_reg      <= '0;
                        res_cell_reg <= 1'b0;
                        res_step_reg <= 1'b0;
                        case (opcode_t'(s_opcode))
                            OP_WRITE, OP_READ: begin
                                state_reg <= ST_FETCH;
                            end
                            OP_STEP: begin
                                state_reg <= running_reg ? ST_STEP : ST_FINISH;
                            end
                            default: begin
                                clr_resp_reg <= 1'b1;
                                state_reg    <= ST_CLEAR;
                            end
                        endcase
                    end
                end
                ST_FETCH: begin
                    state_reg <= ST_APPLY;
                end
                ST_APPLY: begin
                    if ((op_reg == OP_READ) && inside_reg) begin
                        res_cell_reg <= rd_data_reg[col_reg];
                    end
                    state_reg <= ST_FINISH;
                end
                ST_STEP: begin
                    up_reg  <= mid_reg;
                    mid_reg <= rd_data_reg;
                    if (cnt_reg == CNTW'(ROWS + 2)) begin
                        bank_reg     <= ~bank_reg;
                        res_step_reg <= 1'b1;
                        state_reg    <= ST_FINISH;
                    end else begin
                        cnt_reg <= cnt_reg + CNTW'(1);
                    end
                end
                ST_FINISH: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_cell_reg  <= res_cell_reg;
                        m_step_reg  <= res_step_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // A command beat holds off the next one until its own work is done.
    `ASSERT_CLK(a_one_cmd_at_a_time, (s_valid && s_ready) |=> !s_ready, "second command accepted")
    // The stepper never writes into the bank it is reading from.
    `ASSERT_NEVER(a_step_bank_split, wr_en && (state_reg == ST_STEP) && (wr_addr[RW] == rd_addr[RW]), "step writes active bank")
    // A result is either a read value or a step flag, never both.
    `ASSERT_NEVER(a_result_exclusive, m_valid && m_cell_out && m_stepped, "read and step result mixed")

endmodule

`default_nettype wire

// ===== bench/tb_life_generation_engine_core.sv =====
// Self-checking bench for life_generation_engine_core: cell writes, reads, clears and
// generation steps on the 32 x 32 toroidal grid, with a grid model kept in the bench.
// Depends on lge_pkg and the RTL of the engine.
`timescale 1ns / 100ps

module tb_life_generation_engine_core;

    import lge_pkg::*;

    localparam int GRID_ROWS = ROWS_DEF;
    localparam int GRID_COLS = COLS_DEF;
    localparam int LONG_HOLD = 300;

    typedef struct packed {
        opcode_t           op;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic              live;
    } life_cmd_t;

    typedef struct packed {
        logic cell_out;
        logic stepped;
    } life_result_t;

    logic                aclk;
    logic                aresetn = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic                cfg_data = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [OPCODE_W-1:0] s_opcode = '0;
    logic [IDX_W-1:0]    s_row_index = '0;
    logic [IDX_W-1:0]    s_col_index = '0;
    logic                s_cell_in = 1'b0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic                m_cell_out;
    logic                m_stepped;

    // Grid model and the running register as the bench sees them.
    bit           grid_now [GRID_ROWS][GRID_COLS];
    bit           run_enable = 1'b0;

    life_cmd_t    pending_cmds[$];
    life_result_t expected_results[$];
    int           queued_total = 0;
    int           result_beats = 0;
    int           mismatch_count = 0;
    int           idle_pct = 0;
    int           tx_gap = 0;
    int           rx_gap = 0;
    int           hold_requests = 0;
    int           hold_seen = 0;
    int           hold_left = 0;

    life_generation_engine_core #(
        .ROWS(GRID_ROWS),
        .COLS(GRID_COLS)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_opcode   (s_opcode),
        .s_row_index(s_row_index),
        .s_col_index(s_col_index),
        .s_cell_in  (s_cell_in),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_cell_out (m_cell_out),
        .m_stepped  (m_stepped)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Applies one command to the grid model and returns the beat it should produce.
    function automatic life_result_t apply_command(life_cmd_t cmd);
        life_result_t res;
        bit           fresh [GRID_ROWS][GRID_COLS];
        int           n;
        int           up;
        int           down;
        int           left;
        int           right;
        res = '0;
        case (cmd.op)
            OP_WRITE: grid_now[cmd.row][cmd.col] = cmd.live;
            OP_READ:  res.cell_out = grid_now[cmd.row][cmd.col];
            OP_STEP: begin
                if (run_enable) begin
                    for (int r = 0; r < GRID_ROWS; r++) begin
                        up   = (r + GRID_ROWS - 1) % GRID_ROWS;
                        down = (r + 1) % GRID_ROWS;
                        for (int c = 0; c < GRID_COLS; c++) begin
                            left  = (c + GRID_COLS - 1) % GRID_COLS;
                            right = (c + 1) % GRID_COLS;
                            n = grid_now[up][left] + grid_now[up][c] + grid_now[up][right]
                              + grid_now[r][left] + grid_now[r][right]
                              + grid_now[down][left] + grid_now[down][c]
                              + grid_now[down][right];
                            fresh[r][c] = grid_now[r][c] ? (n == 2 || n == 3) : (n == 3);
                        end
                    end
                    grid_now = fresh;
                    res.stepped = 1'b1;
                end
            end
            OP_CLEAR: begin
                foreach (grid_now[r, c]) grid_now[r][c] = 1'b0;
            end
            default: ;
        endcase
        return res;
    endfunction

    // Command driver: presents queued commands, with random gaps between beats while idle_pct is nonzero.
    always @(posedge aclk) begin : cmd_driver
        life_cmd_t nxt;
        life_cmd_t taken;
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_gap  <= 0;
        end else begin
            if (s_valid && s_ready) begin
                taken.op   = opcode_t'(s_opcode);
                taken.row  = s_row_index;
                taken.col  = s_col_index;
                taken.live = s_cell_in;
                expected_results = {expected_results, apply_command(taken)};
            end
            if (!(s_valid && !s_ready)) begin
                if (tx_gap != 0) begin
                    tx_gap  <= tx_gap - 1;
                    s_valid <= 1'b0;
                end else if (pending_cmds.size() != 0 && idle_pct != 0
                             && $urandom_range(99, 0) < idle_pct) begin
                    tx_gap  <= $urandom_range(4, 0);
                    s_valid <= 1'b0;
                end else if (pending_cmds.size() != 0) begin
                    nxt = pending_cmds.pop_front();
                    s_valid     <= 1'b1;
                    s_opcode    <= nxt.op;
                    s_row_index <= nxt.row;
                    s_col_index <= nxt.col;
                    s_cell_in   <= nxt.live;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here so the sink only sees the remaining cycles.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            hold_seen <= 0;
        end else if (hold_seen != hold_requests) begin
            hold_seen <= hold_requests;
            hold_left <= LONG_HOLD;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Result monitor and ready generator.
    always @(posedge aclk) begin : result_sink
        life_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_gap  <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result beat %0d arrived with nothing expected", result_beats);
                end else begin
                    want = expected_results.pop_front();
                    if (m_cell_out !== want.cell_out || m_stepped !== want.stepped) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("result beat %0d differs: cell_out %b/%b stepped %b/%b",
                                     result_beats, want.cell_out, m_cell_out,
                                     want.stepped, m_stepped);
                    end
                end
                result_beats++;
            end
            if (hold_left != 0) begin
                m_ready <= 1'b0;
            end else if (rx_gap != 0) begin
                rx_gap  <= rx_gap - 1;
                m_ready <= 1'b0;
            end else if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
                rx_gap  <= $urandom_range(4, 0);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic push_cmd(opcode_t op, int row, int col, bit live);
        life_cmd_t cmd;
        cmd.op   = op;
        cmd.row  = row[IDX_W-1:0];
        cmd.col  = col[IDX_W-1:0];
        cmd.live = live;
        pending_cmds = {pending_cmds, cmd};
        queued_total++;
    endtask

    task automatic write_running(bit value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        run_enable = value;
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        while (pending_cmds.size() != 0 || s_valid || expected_results.size() != 0)
            @(negedge aclk);
    endtask

    // Mostly small live patterns followed by steps and reads near them, with
    // some fully random commands mixed in.
    task automatic queue_random(int count);
        int stop_at;
        int base_r;
        int base_c;
        stop_at = queued_total + count;
        while (queued_total < stop_at) begin
            if ($urandom_range(4, 0) == 0) begin
                repeat ($urandom_range(4, 1))
                    push_cmd(opcode_t'($urandom_range(3, 0)), $urandom_range(31, 0),
                             $urandom_range(31, 0), $urandom_range(1, 0));
            end else begin
                base_r = $urandom_range(31, 0);
                base_c = $urandom_range(31, 0);
                repeat ($urandom_range(12, 3))
                    push_cmd(OP_WRITE, (base_r + $urandom_range(4, 0)) % GRID_ROWS,
                             (base_c + $urandom_range(4, 0)) % GRID_COLS,
                             $urandom_range(7, 0) != 0);
                repeat ($urandom_range(3, 1))
                    push_cmd(OP_STEP, $urandom_range(31, 0), $urandom_range(31, 0),
                             $urandom_range(1, 0));
                repeat ($urandom_range(6, 2))
                    push_cmd(OP_READ, (base_r + $urandom_range(6, 0) + 31) % GRID_ROWS,
                             (base_c + $urandom_range(6, 0) + 31) % GRID_COLS,
                             $urandom_range(1, 0));
                if ($urandom_range(9, 0) == 0)
                    push_cmd(OP_CLEAR, $urandom_range(31, 0), $urandom_range(31, 0),
                             $urandom_range(1, 0));
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        write_running(1'b0);

        // Stopped engine: corner cells, an untouched cell, an ignored step, clear.
        @(negedge aclk);
        idle_pct = 25;
        push_cmd(OP_WRITE, 0, 0, 1'b1);
        push_cmd(OP_WRITE, 31, 31, 1'b1);
        push_cmd(OP_WRITE, 31, 0, 1'b1);
        push_cmd(OP_READ, 0, 0, 1'b0);
        push_cmd(OP_READ, 31, 31, 1'b0);
        push_cmd(OP_READ, 15, 16, 1'b1);
        push_cmd(OP_STEP, 31, 31, 1'b1);
        push_cmd(OP_WRITE, 31, 31, 1'b0);
        push_cmd(OP_READ, 31, 31, 1'b1);
        push_cmd(OP_CLEAR, 0, 0, 1'b0);
        push_cmd(OP_READ, 0, 0, 1'b0);
        wait_drained();
        write_running(1'b1);

        // Running: blinkers straddling the row edge and the column edge, plus a
        // lone cell that must die.
        @(negedge aclk);
        push_cmd(OP_WRITE, 31, 5, 1'b1);
        push_cmd(OP_WRITE, 0, 5, 1'b1);
        push_cmd(OP_WRITE, 1, 5, 1'b1);
        push_cmd(OP_WRITE, 10, 31, 1'b1);
        push_cmd(OP_WRITE, 10, 0, 1'b1);
        push_cmd(OP_WRITE, 10, 1, 1'b1);
        push_cmd(OP_WRITE, 20, 20, 1'b1);
        push_cmd(OP_STEP, 0, 0, 1'b0);
        push_cmd(OP_READ, 0, 4, 1'b0);
        push_cmd(OP_READ, 0, 6, 1'b0);
        push_cmd(OP_READ, 31, 5, 1'b0);
        push_cmd(OP_READ, 9, 0, 1'b0);
        push_cmd(OP_READ, 11, 0, 1'b0);
        push_cmd(OP_READ, 20, 20, 1'b0);

        // The sender keeps offering while the receiver holds off for a long time.
        queue_random(60);
        hold_requests++;
        queue_random(90);
        // The sender stops until every outstanding beat is back.
        wait_drained();
        queue_random(100);
        wait_drained();

        write_running(1'b0);
        @(negedge aclk);
        idle_pct = 40;
        queue_random(120);
        wait_drained();

        write_running(1'b1);
        @(negedge aclk);
        idle_pct = 0;
        queue_random(150);
        wait_drained();

        repeat (40) @(posedge aclk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #800000;
        $display("Mismatches found");
        $finish;
    end

endmodule
